// ===== src/sse_pkg.sv =====
// Shared constants and types for the sorted set engine.
// Used by the storage cell and by the top level; no dependencies.
package sse_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int REQ_USER_W = 8;

   localparam logic [OP_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [OP_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [OP_W-1:0] REQ_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic             cmp;        // latch compare flags against cmp_value
      logic [KEY_W-1:0] cmp_value;
      logic             ins;        // make room and insert wr_value
      logic             del;        // close the gap at the match
      logic [KEY_W-1:0] wr_value;
   } cell_ctl_type;

endpackage

// ===== src/sse_cell.sv =====
// One storage cell of the sorted set engine's key chain.
// Depends on sse_pkg for the key width and the control struct.
module sse_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sse_pkg::cell_ctl_type       ctl,
   input  logic                        occupied,
   input  logic                        at_fill,
   input  logic                        prev_ge,
   input  logic [sse_pkg::KEY_W-1:0]   prev_key,
   input  logic [sse_pkg::KEY_W-1:0]   next_key,
   output logic [sse_pkg::KEY_W-1:0]   key,
   output logic                        ge,
   output logic                        eq
);
   import sse_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic             ge_ff, ge_in;
   logic             eq_ff, eq_in;

   always_comb begin
      ge_in = ge_ff;
      eq_in = eq_ff;
      if (ctl.cmp) begin
         ge_in = occupied && ($signed(key_ff) >= $signed(ctl.cmp_value));
         eq_in = occupied && (key_ff == ctl.cmp_value);
      end
   end

   // The ge flags form a contiguous run up to the fill mark, so a cell
   // whose lower neighbor is at or above the key takes that neighbor's key.
   always_comb begin
      key_in = key_ff;
      if (ctl.ins) begin
         if (prev_ge) begin
            key_in = prev_key;
         end else if (ge_ff || at_fill) begin
            key_in = ctl.wr_value;
         end
      end else if (ctl.del) begin
         if (ge_ff) begin
            key_in = next_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         ge_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         ge_ff <= ge_in;
         eq_ff <= eq_in;
      end
   end

   assign key = key_ff;
   assign ge  = ge_ff;
   assign eq  = eq_ff;

endmodule

// ===== src/sorted_set_engine_core.sv =====
// Top level of the sorted set engine: request sequencer, chain of key cells,
// running count and sum, and the response register. Depends on sse_pkg, sse_cell.
//
// The engine keeps a set of distinct signed 32-bit keys in ascending order in
// a chain of CAPACITY cells. Each request word on the req_ channel carries an
// operation in req_tuser (insert, delete, or look up; the unused code acts as a
// look up) and a key in req_tdata. Each request produces exactly one response
// word on the rsp_ channel with the hit flag, a status code, the element count
// after the request and the wrapping sum of all held keys.
//
// In the accept cycle every cell compares its key with the incoming key in
// parallel and latches a greater-or-equal flag and an equal flag. In the
// commit state the flags select the operation, and every cell loads its own
// key, a neighbor's key or the new key in one shift step. The response is
// registered and appears the cycle after the commit; a new request is accepted
// only once the sequencer is back in the idle state.
//
// Reset clears the count, the sum and all handshake state; cell contents are
// don't-care because only cells below the count are ever looked at. If the
// receiver stalls, the response word holds and at most one more request is
// accepted once the held word is taken.
module sorted_set_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] value
   input  logic [sse_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] req_type, [7:2] zero
   input  logic [sse_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hit, [2:1] status, [9:3] count, [41:10] total, [47:42] zero
   output logic [sse_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import sse_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_COMMIT = 1'b1;

   logic                state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    value_ff, value_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [KEY_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                present;
   logic                full;
   logic                do_ins, do_del;
   logic [STATUS_W-1:0] status;
   cell_ctl_type        ctl;

   logic [KEY_W-1:0]    cell_key [CAPACITY];
   logic [CAPACITY-1:0] cell_ge;
   logic [CAPACITY-1:0] cell_eq;

   // A new request may enter when the sequencer is idle and the response
   // register is empty or being drained in this cycle.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Keys are distinct, so at most one equal flag is set.
   assign present = |cell_eq;
   assign full    = (fill_ff == FILL_W'(CAPACITY));

   always_comb begin
      do_ins = 1'b0;
      do_del = 1'b0;
      status = STATUS_DONE;
      case (op_ff)
         REQ_INSERT: begin
            if (present) begin
               status = STATUS_DUPLICATE;
            end else if (full) begin
               status = STATUS_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (!present) begin
               status = STATUS_NOT_FOUND;
            end else begin
               do_del = 1'b1;
            end
         end
         default: begin
            status = STATUS_DONE;
         end
      endcase
   end

   always_comb begin
      ctl.cmp       = accept;
      ctl.cmp_value = req_tdata[KEY_W-1:0];
      ctl.ins       = (state_ff == ST_COMMIT) && do_ins;
      ctl.del       = (state_ff == ST_COMMIT) && do_del;
      ctl.wr_value  = value_ff;
   end

   // The chain: each cell sees its neighbors' keys and its lower neighbor's
   // compare flag. The bottom cell has no lower neighbor and the top cell
   // refills from itself on a delete.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic             prev_ge;
      logic [KEY_W-1:0] prev_key;
      logic [KEY_W-1:0] next_key;

      if (i == 0) begin : g_bottom
         assign prev_ge  = 1'b0;
         assign prev_key = cell_key[i];
      end else begin : g_mid_lo
         assign prev_ge  = cell_ge[i-1];
         assign prev_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign next_key = cell_key[i];
      end else begin : g_mid_hi
         assign next_key = cell_key[i+1];
      end

      sse_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .occupied (FILL_W'(i) < fill_ff),
         .at_fill  (FILL_W'(i) == fill_ff),
         .prev_ge  (prev_ge),
         .prev_key (prev_key),
         .next_key (next_key),
         .key      (cell_key[i]),
         .ge       (cell_ge[i]),
         .eq       (cell_eq[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_tuser[OP_W-1:0];
               value_in = req_tdata[KEY_W-1:0];
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (do_ins) begin
               fill_in = fill_ff + FILL_W'(1);
               sum_in  = sum_ff + value_ff;
            end else if (do_del) begin
               fill_in = fill_ff - FILL_W'(1);
               sum_in  = sum_ff - value_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = {(RSP_DATA_W - KEY_W - COUNT_W - STATUS_W - 1)'(0),
                            sum_in, COUNT_W'(fill_in), status, present};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
